// ===== rtl/core/rgb_to_hsl_assert.svh =====
// Assertion macros used by the checker file.
`ifndef RGB_TO_HSL_ASSERT_SVH
`define RGB_TO_HSL_ASSERT_SVH

// Same-cycle implication, masked while reset is active.
`define RTH_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_hsl: check failed");

// Next-cycle implication, masked while reset is active.
`define RTH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgb_to_hsl: check failed");

// Next-cycle implication that also holds through reset.
`define RTH_ASSERT_NEXT_ALWAYS(name, ante, cons) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("rgb_to_hsl: check failed");

`endif

// ===== rtl/core/rth_pkg.sv =====
package rth_pkg;

    typedef logic [1:0] t_lane;

    localparam int    NUM_LANES = 3;
    localparam t_lane LANE_HUE  = 2'd0;
    localparam t_lane LANE_SAT  = 2'd1;
    localparam t_lane LANE_LIT  = 2'd2;

endpackage

// ===== rtl/core/rth_pix_if.sv =====
interface rth_pix_if #(
    parameter int CB = 8
);
    logic          valid;
    logic          ready;
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/core/rth_hsl_if.sv =====
interface rth_hsl_if #(
    parameter int OB = 16
);
    logic          valid;
    logic          ready;
    logic [OB-1:0] hue;
    logic [OB-1:0] saturation;
    logic [OB-1:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness, input ready);
    modport sink   (input valid, input hue, input saturation, input lightness, output ready);
endinterface

// ===== rtl/core/rgb_to_hsl.sv =====
// rgb_to_hsl: pixel stream conversion from RGB to hue, saturation, lightness.
// Input channel i_pix carries one pixel per item (red, green, blue, each
// value / (2^CHANNEL_BITS - 1)); output channel o_hsl carries one result
// item per pixel: hue as a fraction of a turn over 2^OUT_BITS, saturation
// and lightness over 2^OUT_BITS - 1, all rounded to nearest, halves up.
// Both channels use valid/ready; an item moves when both are high.
// Throughput: one pixel per clock while the receiver keeps o_hsl.ready high.
// Datapath: one front cell finds max, min and chroma and forms the three
// dividends, then a row of OUT_BITS + 1 divider cells each retires one
// quotient bit, most significant first.
// Each cell holds its own valid bit, so bubbles collapse: while the
// receiver stalls the row keeps filling and i_pix.ready drops only once
// every cell is occupied; the last cell doubles as the output register.
// Reset (synchronous, active low) empties every cell; payload is not
// cleared. No configuration and no state carry from one pixel to the next.
module rgb_to_hsl #(
    parameter int CHANNEL_BITS = 8,
    parameter int OUT_BITS     = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rth_pix_if.sink   i_pix,
    rth_hsl_if.source o_hsl
);
    import rth_pkg::*;

    // dividend width covers the hue lane, the widest of the three
    localparam int W = CHANNEL_BITS + OUT_BITS + 5;
    // one extra quotient bit: rounded hue may reach a full turn
    localparam int Q = OUT_BITS + 1;

    logic [Q:0]                                c_valid;
    logic [Q:0]                                c_ready;
    logic [Q:0][NUM_LANES-1:0][W-1:0]          c_rem;
    logic [Q:0][NUM_LANES-1:0][W-1:0]          c_den;
    logic [Q:0][NUM_LANES-1:0][Q-1:0]          c_quot;

    // front cell: compare, chroma, dividend and divisor per lane
    rth_front #(
        .CB (CHANNEL_BITS),
        .OB (OUT_BITS),
        .W  (W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_valid (c_valid[0]),
        .i_ready (c_ready[0]),
        .o_rem   (c_rem[0]),
        .o_den   (c_den[0])
    );

    assign c_quot[0] = '0;

    // divider row: cell k settles quotient bit Q-1-k, most significant first
    for (genvar k = 0; k < Q; k++) begin : g_cell
        rth_div_cell #(
            .W     (W),
            .Q     (Q),
            .SHIFT (Q - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_rem   (c_rem[k]),
            .i_den   (c_den[k]),
            .i_quot  (c_quot[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_rem   (c_rem[k+1]),
            .o_den   (c_den[k+1]),
            .o_quot  (c_quot[k+1])
        );
    end

    // last cell holds the finished item; drop the top hue bit to wrap a full turn
    assign c_ready[Q]       = o_hsl.ready;
    assign o_hsl.valid      = c_valid[Q];
    assign o_hsl.hue        = c_quot[Q][LANE_HUE][OUT_BITS-1:0];
    assign o_hsl.saturation = c_quot[Q][LANE_SAT][OUT_BITS-1:0];
    assign o_hsl.lightness  = c_quot[Q][LANE_LIT][OUT_BITS-1:0];
endmodule

// ===== rtl/core/rth_front.sv =====
module rth_front #(
    parameter int CB = 8,
    parameter int OB = 16,
    parameter int W  = CB + OB + 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [CB-1:0]                        i_red,
    input  logic [CB-1:0]                        i_green,
    input  logic [CB-1:0]                        i_blue,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [rth_pkg::NUM_LANES-1:0][W-1:0] o_rem,
    output logic [rth_pkg::NUM_LANES-1:0][W-1:0] o_den
);
    import rth_pkg::*;

    localparam logic [CB:0] CH_MAX = {1'b0, {CB{1'b1}}};

    logic                          r_valid;
    logic [NUM_LANES-1:0][W-1:0]   r_rem;
    logic [NUM_LANES-1:0][W-1:0]   r_den;
    logic [NUM_LANES-1:0][W-1:0]   n_rem;
    logic [NUM_LANES-1:0][W-1:0]   n_den;
    logic [CB-1:0]                 mx;
    logic [CB-1:0]                 mn;
    logic [CB-1:0]                 chroma;
    logic [CB:0]                   sum;
    logic [CB:0]                   sden;
    logic [CB+2:0]                 hnum;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;

    always_comb begin
        mx = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        mn = i_red;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;
        chroma = mx - mn;
        sum    = {1'b0, mx} + {1'b0, mn};
        sden   = (sum >= CH_MAX) ? ((CH_MAX << 1) - sum) : sum;

        // hexcone sector numerator, red wins ties, then green
        if (mx == i_red) begin
            if (i_green >= i_blue) begin
                hnum = (CB+3)'(i_green) - (CB+3)'(i_blue);
            end else begin
                hnum = ((CB+3)'(chroma) << 2) + ((CB+3)'(chroma) << 1)
                     - (CB+3)'(i_blue) + (CB+3)'(i_green);
            end
        end else if (mx == i_green) begin
            hnum = ((CB+3)'(chroma) << 1) + (CB+3)'(i_blue) - (CB+3)'(i_red);
        end else begin
            hnum = ((CB+3)'(chroma) << 2) + (CB+3)'(i_red) - (CB+3)'(i_green);
        end

        // rounded divide: (2*num + den) / (2*den)
        if (chroma == '0) begin
            n_rem[LANE_HUE] = '0;
            n_den[LANE_HUE] = W'(1);
            n_rem[LANE_SAT] = '0;
            n_den[LANE_SAT] = W'(1);
        end else begin
            n_rem[LANE_HUE] = (W'(hnum) << (OB + 1))
                            + (W'(chroma) << 2) + (W'(chroma) << 1);
            n_den[LANE_HUE] = (W'(chroma) << 3) + (W'(chroma) << 2);
            n_rem[LANE_SAT] = (((W'(chroma) << OB) - W'(chroma)) << 1) + W'(sden);
            n_den[LANE_SAT] = W'(sden) << 1;
        end
        n_rem[LANE_LIT] = (((W'(sum) << OB) - W'(sum)) << 1) + (W'(CH_MAX) << 1);
        n_den[LANE_LIT] = W'(CH_MAX) << 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem <= n_rem;
            r_den <= n_den;
        end
    end
endmodule

// ===== rtl/core/rth_div_cell.sv =====
module rth_div_cell #(
    parameter int W     = 29,
    parameter int Q     = 17,
    parameter int SHIFT = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [rth_pkg::NUM_LANES-1:0][W-1:0] i_rem,
    input  logic [rth_pkg::NUM_LANES-1:0][W-1:0] i_den,
    input  logic [rth_pkg::NUM_LANES-1:0][Q-1:0] i_quot,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [rth_pkg::NUM_LANES-1:0][W-1:0] o_rem,
    output logic [rth_pkg::NUM_LANES-1:0][W-1:0] o_den,
    output logic [rth_pkg::NUM_LANES-1:0][Q-1:0] o_quot
);
    import rth_pkg::*;

    logic                        r_valid;
    logic [NUM_LANES-1:0][W-1:0] r_rem;
    logic [NUM_LANES-1:0][W-1:0] r_den;
    logic [NUM_LANES-1:0][Q-1:0] r_quot;
    logic [NUM_LANES-1:0][W-1:0] n_rem;
    logic [NUM_LANES-1:0][Q-1:0] n_quot;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_quot  = r_quot;

    // one restoring step per lane against the divisor shifted to this bit
    always_comb begin
        n_rem  = i_rem;
        n_quot = i_quot;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (i_rem[l] >= (i_den[l] << SHIFT)) begin
                n_rem[l]         = i_rem[l] - (i_den[l] << SHIFT);
                n_quot[l][SHIFT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_rem  <= n_rem;
            r_den  <= i_den;
            r_quot <= n_quot;
        end
    end
endmodule

// ===== rtl/core/rth_checker.sv =====
`include "rgb_to_hsl_assert.svh"

module rth_checker #(
    parameter int OB = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input logic [OB-1:0] i_hue,
    input logic [OB-1:0] i_sat,
    input logic [OB-1:0] i_lit
);
    // hold a stalled result
    `RTH_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_hue) && $stable(i_sat) && $stable(i_lit))
    // an empty output stage means the whole row can take a pixel
    `RTH_ASSERT_IMPLY(a_ready_when_drained, !i_out_valid, i_in_ready)
    // reset empties the row
    `RTH_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !i_out_valid)
endmodule

bind rgb_to_hsl rth_checker #(
    .OB (OUT_BITS)
) u_rth_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_hsl.valid),
    .i_out_ready (o_hsl.ready),
    .i_hue       (o_hsl.hue),
    .i_sat       (o_hsl.saturation),
    .i_lit       (o_hsl.lightness)
);
